FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL of the cluster table engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, checked on every rising edge outside reset.
`define CFT_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error(msg);

// Condition that must never be seen on a rising edge outside reset.
`define CFT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error(msg);

`endif

FILE: rtl/core/cft_pkg.sv
`default_nettype none

package cft_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 4096;
	localparam int unsigned ENTRY_W = 16;
	// Widest first data sector: 16-bit reserved + 8x16 tables + 22-bit root size.
	localparam int unsigned FD_W = 25;
	localparam int unsigned BPS_W = 13;
	localparam int unsigned SPC_W = 8;
	localparam int unsigned CNT_OUT_W = 13;

	localparam logic [ENTRY_W-1:0] LINK_FREE = 16'h0000;
	localparam logic [ENTRY_W-1:0] LINK_EOC = 16'hFFFF;
	localparam logic [ENTRY_W-1:0] LINK_END_MIN = 16'hFFF8;
	localparam logic [ENTRY_W-1:0] ALLOC_CAP = 16'hFFF0;
	localparam logic [ENTRY_W-1:0] FIRST_CLUSTER = 16'd2;
	// Root directory slots are 32 bytes each.
	localparam int unsigned ROOT_SLOT_SHIFT = 5;

	typedef enum logic [1:0] {
		CMD_FOLLOW = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_FREE = 2'd2,
		CMD_LOAD = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_RANGE = 2'd2,
		ST_LONG = 2'd3
	} status_t;

	typedef enum logic [7:0] {
		CFG_BPS = 8'd0,
		CFG_SPC = 8'd1,
		CFG_RSV = 8'd2,
		CFG_COPIES = 8'd3,
		CFG_SPT = 8'd4,
		CFG_ROOT = 8'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		G_IDLE,
		G_DIV,
		G_SUM
	} geom_state_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FOL_RD,
		S_FOL_DATA,
		S_ALLOC,
		S_FREE_CHK,
		S_FREE_RD,
		S_OFFSET,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic [BPS_W-1:0] bps;
		logic [SPC_W-1:0] spc;
		logic [FD_W-1:0] first_data;
	} geom_t;

	typedef struct packed {
		status_t status;
		logic [ENTRY_W-1:0] cluster_out;
		logic chain_end;
		logic [31:0] byte_offset;
		logic [CNT_OUT_W-1:0] freed_count;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/core/cft_geom.sv
`default_nettype none

module cft_geom
	import cft_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	input wire logic [7:0] cfg_index,
	input wire logic [15:0] cfg_data,
	output logic busy,
	output geom_t geom
);

	localparam int unsigned DIV_W = 22;
	localparam int unsigned DCNT_W = $clog2(DIV_W + 1);

	logic [BPS_W-1:0] bps_q;
	logic [SPC_W-1:0] spc_q;
	logic [15:0] rsv_q;
	logic [7:0] copies_q;
	logic [15:0] spt_q;
	logic [15:0] root_q;

	geom_state_t gst_q, gst_d;
	logic pend_q;
	logic start;
	logic [DIV_W-1:0] quo_q;
	logic [BPS_W-1:0] rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [23:0] prod_q;
	logic [FD_W-1:0] fd_q;

	logic [DIV_W-1:0] num;
	logic [BPS_W:0] trial;
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bps_q <= 13'd512;
			spc_q <= 8'd4;
			rsv_q <= 16'd1;
			copies_q <= 8'd2;
			spt_q <= 16'd16;
			root_q <= 16'd512;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BPS: bps_q <= cfg_data[BPS_W-1:0];
				CFG_SPC: spc_q <= cfg_data[SPC_W-1:0];
				CFG_RSV: rsv_q <= cfg_data;
				CFG_COPIES: copies_q <= cfg_data[7:0];
				CFG_SPT: spt_q <= cfg_data;
				CFG_ROOT: root_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Root sectors are ceil(root_q * 32 / bps_q), one quotient bit per cycle.
	assign num = DIV_W'({root_q, {ROOT_SLOT_SHIFT{1'b0}}}) + DIV_W'(bps_q) - DIV_W'(1);
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign take = trial >= {1'b0, bps_q};
	assign start = (gst_q == G_IDLE) && pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gst_q <= G_IDLE;
			pend_q <= 1'b1;
		end else begin
			gst_q <= gst_d;
			if (cfg_valid) begin
				pend_q <= 1'b1;
			end else if (start) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_comb begin
		gst_d = gst_q;
		unique case (gst_q)
			G_IDLE: if (pend_q) begin
				gst_d = G_DIV;
			end
			G_DIV: if (dcnt_q == DCNT_W'(1)) begin
				gst_d = G_SUM;
			end
			G_SUM: gst_d = G_IDLE;
			default: gst_d = G_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			dcnt_q <= DCNT_W'(DIV_W);
			prod_q <= 24'(copies_q * spt_q);
		end else if (gst_q == G_DIV) begin
			rem_q <= take ? BPS_W'(trial - {1'b0, bps_q}) : trial[BPS_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], take};
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end
		if (gst_q == G_SUM) begin
			// A zero sector size counts as no root directory sectors.
			fd_q <= FD_W'(rsv_q) + FD_W'(prod_q)
				+ ((bps_q == '0) ? '0 : FD_W'(quo_q));
		end
	end

	assign busy = pend_q || (gst_q != G_IDLE);
	assign geom.bps = bps_q;
	assign geom.spc = spc_q;
	assign geom.first_data = fd_q;

endmodule

`default_nettype wire

FILE: rtl/core/cft_offs.sv
`default_nettype none

module cft_offs
	import cft_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [ENTRY_W-1:0] clus,
	input wire geom_t geom,
	output logic done,
	output logic [31:0] offset
);

	logic v_s1, v_s2, v_s3;
	logic [31:0] rel_s1;
	logic [31:0] sec_s2;
	logic [31:0] off_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Clusters 0 and 1 wrap below zero; everything is taken modulo 2^32.
	always_ff @(posedge clk) begin
		rel_s1 <= 32'((32'(clus) - 32'(FIRST_CLUSTER)) * 32'(geom.spc));
		sec_s2 <= 32'(geom.first_data) + rel_s1;
		off_s3 <= 32'(sec_s2 * 32'(geom.bps));
	end

	assign done = v_s3;
	assign offset = off_s3;

endmodule

`default_nettype wire

FILE: rtl/core/cft_table.sv
`default_nettype none
`include "assert_macros.svh"

module cft_table
	import cft_pkg::*;
#(
	parameter int unsigned ENTRIES = TABLE_ENTRIES_DEF,
	localparam int unsigned AW = $clog2(ENTRIES)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rd_en,
	input wire logic [AW-1:0] rd_addr,
	output logic [ENTRY_W-1:0] rd_data,
	input wire logic wr_en,
	input wire logic [AW-1:0] wr_addr,
	input wire logic [ENTRY_W-1:0] wr_data,
	output logic ready
);

	logic [ENTRY_W-1:0] mem [ENTRIES];
	logic clr_busy_q;
	logic [AW-1:0] clr_q;

	logic we;
	logic [AW-1:0] wa;
	logic [ENTRY_W-1:0] wd;

	// After reset every entry is written to zero, one per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_q == AW'(ENTRIES - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	assign we = clr_busy_q || wr_en;
	assign wa = clr_busy_q ? clr_q : wr_addr;
	assign wd = clr_busy_q ? LINK_FREE : wr_data;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign ready = !clr_busy_q;

	`CFT_NEVER(a_no_access_in_clear, clk, arst_n, clr_busy_q && (wr_en || rd_en), "table accessed during clearing pass")

endmodule

`default_nettype wire

FILE: rtl/core/fat16_cluster_table_engine.sv
// FAT16 cluster table engine.
// Commands enter on the s_axis channel (tuser = command, tdata = cluster and
// load value); each item gives exactly one result item on m_axis (tuser =
// status, tdata = link, end flag, byte offset, freed count).
// Geometry registers are written through cfg_valid/cfg_index/cfg_data, which
// is always ready. After each write the first data sector is recomputed by a
// serial divider, during which no item is accepted. Allocation time grows with
// the scan position of the free cluster it finds, and freeing a chain with the
// number of clusters it releases. The table memory has one read and one write
// port and the scan and walk go through it one entry at a time. After reset the
// table is cleared by a pass over every entry and the geometry is computed;
// s_axis_tready stays low until both are done.
// The result sits in an output register; while m_axis_tready is low the next
// item may still be accepted and worked, and it then waits for that register.
`default_nettype none
`include "assert_macros.svh"

module fat16_cluster_table_engine
	import cft_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [31:0] s_axis_tdata, // cluster, entry_value
	input wire logic [1:0] s_axis_tuser, // cmd
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [63:0] m_axis_tdata, // cluster_out, chain_end, byte_offset, freed_count
	output logic [1:0] m_axis_tuser, // status
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [7:0] cfg_index,
	input wire logic [15:0] cfg_data
);

	localparam int unsigned AW = $clog2(TABLE_ENTRIES);
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
	localparam int unsigned SCAN_LIMIT =
		(TABLE_ENTRIES < 32'(ALLOC_CAP)) ? TABLE_ENTRIES : 32'(ALLOC_CAP);
	localparam logic [CW-1:0] SCAN_LIM = CW'(SCAN_LIMIT);
	localparam logic [CW-1:0] ENT_CW = CW'(TABLE_ENTRIES);
	localparam logic [ENTRY_W:0] ENT_WIDE = (ENTRY_W + 1)'(TABLE_ENTRIES);

	geom_t geom;
	logic geom_busy;
	logic tbl_ready;

	logic tbl_rd, tbl_wr;
	logic [AW-1:0] tbl_raddr, tbl_waddr;
	logic [ENTRY_W-1:0] tbl_wdata, tbl_rdata;

	logic offs_start, offs_done;
	logic [ENTRY_W-1:0] offs_clus;
	logic [31:0] offs_offset;

	seq_state_t state_q, state_d;
	logic pend_s1;
	logic [AW-1:0] addr_s1;
	logic [CW-1:0] scan_q;
	logic [CW-1:0] cnt_q;
	logic [ENTRY_W-1:0] clus_q;
	status_t status_q;
	logic [ENTRY_W-1:0] cl_out_q;
	logic end_q;
	logic [31:0] off_q;
	result_t out_q;
	logic out_vld_q;

	cmd_t in_cmd;
	logic [ENTRY_W-1:0] in_cluster, in_value;
	logic in_acc, in_range;
	logic out_free;
	logic alloc_found, scan_more;
	logic walk_stop, walk_big, walk_long;

	cft_geom u_geom (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.busy(geom_busy),
		.geom(geom)
	);

	cft_table #(
		.ENTRIES(TABLE_ENTRIES)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(tbl_rd),
		.rd_addr(tbl_raddr),
		.rd_data(tbl_rdata),
		.wr_en(tbl_wr),
		.wr_addr(tbl_waddr),
		.wr_data(tbl_wdata),
		.ready(tbl_ready)
	);

	cft_offs u_offs (
		.clk(clk),
		.arst_n(arst_n),
		.start(offs_start),
		.clus(offs_clus),
		.geom(geom),
		.done(offs_done),
		.offset(offs_offset)
	);

	assign cfg_ready = 1'b1;
	assign in_cmd = cmd_t'(s_axis_tuser);
	assign in_cluster = s_axis_tdata[15:0];
	assign in_value = s_axis_tdata[31:16];
	assign s_axis_tready = (state_q == S_IDLE) && !geom_busy && tbl_ready;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign in_range = {1'b0, in_cluster} < ENT_WIDE;
	assign out_free = !out_vld_q || m_axis_tready;

	// The scan keeps one read in flight; addr_s1 is the entry whose data arrives now.
	assign alloc_found = pend_s1 && (tbl_rdata == LINK_FREE);
	assign scan_more = scan_q < SCAN_LIM;

	assign walk_stop = (clus_q < FIRST_CLUSTER) || (clus_q >= LINK_END_MIN);
	assign walk_big = {1'b0, clus_q} >= ENT_WIDE;
	assign walk_long = cnt_q >= ENT_CW;

	assign offs_clus = (state_q == S_ALLOC) ? ENTRY_W'(addr_s1) : clus_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == S_ALLOC) && !alloc_found && scan_more;
			if ((state_q == S_DONE) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		tbl_rd = 1'b0;
		tbl_raddr = clus_q[AW-1:0];
		tbl_wr = 1'b0;
		tbl_waddr = clus_q[AW-1:0];
		tbl_wdata = LINK_FREE;
		offs_start = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_acc) begin
				unique case (in_cmd)
					CMD_FOLLOW: state_d = in_range ? S_FOL_RD : S_DONE;
					CMD_ALLOC: state_d = S_ALLOC;
					CMD_FREE: state_d = S_FREE_CHK;
					CMD_LOAD: begin
						state_d = S_DONE;
						tbl_wr = in_range;
						tbl_waddr = in_cluster[AW-1:0];
						tbl_wdata = in_value;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_FOL_RD: begin
				tbl_rd = 1'b1;
				state_d = S_FOL_DATA;
			end
			S_FOL_DATA: begin
				offs_start = 1'b1;
				state_d = S_OFFSET;
			end
			S_ALLOC: begin
				priority if (alloc_found) begin
					tbl_wr = 1'b1;
					tbl_waddr = addr_s1;
					tbl_wdata = LINK_EOC;
					offs_start = 1'b1;
					state_d = S_OFFSET;
				end else if (scan_more) begin
					tbl_rd = 1'b1;
					tbl_raddr = scan_q[AW-1:0];
				end else if (!pend_s1) begin
					state_d = S_DONE;
				end
			end
			S_FREE_CHK: begin
				priority if (walk_stop || walk_big || walk_long) begin
					state_d = S_DONE;
				end else begin
					tbl_rd = 1'b1;
					state_d = S_FREE_RD;
				end
			end
			S_FREE_RD: begin
				tbl_wr = 1'b1;
				state_d = S_FREE_CHK;
			end
			S_OFFSET: if (offs_done) begin
				state_d = S_DONE;
			end
			S_DONE: if (out_free) begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (in_acc) begin
				clus_q <= in_cluster;
				status_q <= (((in_cmd == CMD_FOLLOW) || (in_cmd == CMD_LOAD)) && !in_range)
					? ST_RANGE : ST_OK;
				cl_out_q <= '0;
				end_q <= 1'b0;
				off_q <= '0;
				cnt_q <= '0;
				scan_q <= CW'(FIRST_CLUSTER);
			end
			S_FOL_DATA: begin
				cl_out_q <= tbl_rdata;
				end_q <= (tbl_rdata < FIRST_CLUSTER) || (tbl_rdata >= LINK_END_MIN);
			end
			S_ALLOC: begin
				priority if (alloc_found) begin
					cl_out_q <= ENTRY_W'(addr_s1);
				end else if (scan_more) begin
					addr_s1 <= scan_q[AW-1:0];
					scan_q <= scan_q + CW'(1);
				end else if (!pend_s1) begin
					status_q <= ST_FULL;
				end
			end
			S_FREE_CHK: begin
				priority if (walk_stop) begin
					status_q <= ST_OK;
				end else if (walk_big) begin
					status_q <= ST_RANGE;
				end else if (walk_long) begin
					status_q <= ST_LONG;
				end
			end
			S_FREE_RD: begin
				cnt_q <= cnt_q + CW'(1);
				clus_q <= tbl_rdata;
			end
			S_OFFSET: if (offs_done) begin
				off_q <= offs_offset;
			end
			S_DONE: if (out_free) begin
				out_q.status <= status_q;
				out_q.cluster_out <= cl_out_q;
				out_q.chain_end <= end_q;
				out_q.byte_offset <= off_q;
				out_q.freed_count <= CNT_OUT_W'(cnt_q);
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser = out_q.status;
	assign m_axis_tdata = {2'b00, out_q.freed_count, out_q.byte_offset, out_q.chain_end,
		out_q.cluster_out};

	`CFT_ASSERT(a_walk_order, clk, arst_n, (state_q == S_FREE_RD) |-> ($past(state_q) == S_FREE_CHK), "free walk read without a preceding check")
	`CFT_ASSERT(a_count_bound, clk, arst_n, cnt_q <= ENT_CW, "freed count beyond table size")
	`CFT_ASSERT(a_scan_track, clk, arst_n, ((state_q == S_ALLOC) && pend_s1) |-> ((CW'(addr_s1) + CW'(1)) == scan_q), "scan address in flight out of step with scan pointer")

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
module tb_top;
	import cft_pkg::*;

	localparam int TABLE_N = TABLE_ENTRIES_DEF;
	localparam int STALL_LIMIT = 60000;
	localparam int LONG_HOLD = 400;
	localparam int END_SETTLE = 40;
	localparam int PHASES = 7;
	localparam int PHASE_ITEMS = 200;
	localparam int PRINT_CAP = 100;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata; // cluster, entry_value
	logic [1:0] s_axis_tuser; // cmd
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [63:0] m_axis_tdata; // cluster_out, chain_end, byte_offset, freed_count
	logic [1:0] m_axis_tuser; // status
	logic cfg_valid;
	logic cfg_ready;
	logic [7:0] cfg_index;
	logic [15:0] cfg_data;

	typedef struct packed {
		cmd_t cmd;
		logic [15:0] clus;
		logic [15:0] val;
		bit typed;
		result_t want;
	} step_t;

	// Mirror of the allocation table and the volume geometry.
	logic [15:0] fat [TABLE_N];
	logic [31:0] g_bps, g_spc, g_rsv, g_copies, g_spt, g_root;

	result_t awaited[$];
	logic [15:0] granted[$];
	step_t script[$];
	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	bit hold_request = 1'b0;

	fat16_cluster_table_engine #(.TABLE_ENTRIES(TABLE_N)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] cluster_offset(logic [31:0] clus);
		logic [31:0] root_sec;
		logic [31:0] sector;
		root_sec = '0;
		// A zero sector size leaves the root directory with no sectors.
		if (g_bps != 0)
			root_sec = ((g_root << ROOT_SLOT_SHIFT) + (g_bps - 32'd1)) / g_bps;
		sector = g_rsv + g_copies * g_spt + root_sec + (clus - 32'd2) * g_spc;
		return sector * g_bps;
	endfunction

	function automatic result_t run_fat_command(cmd_t cmd, logic [15:0] clus,
			logic [15:0] val);
		result_t r;
		int unsigned c;
		int unsigned nxt;
		int unsigned cap;
		int unsigned cnt;
		r = '0;
		cnt = 0;
		case (cmd)
			CMD_FOLLOW: begin
				if (clus >= TABLE_N) begin
					r.status = ST_RANGE;
				end else begin
					r.cluster_out = fat[clus];
					r.chain_end = (fat[clus] < FIRST_CLUSTER) || (fat[clus] >= LINK_END_MIN);
					r.byte_offset = cluster_offset({16'h0, clus});
				end
			end
			CMD_ALLOC: begin
				cap = (TABLE_N < ALLOC_CAP) ? TABLE_N : ALLOC_CAP;
				c = FIRST_CLUSTER;
				while (c < cap && fat[c] != LINK_FREE)
					c++;
				if (c >= cap) begin
					r.status = ST_FULL;
				end else begin
					fat[c] = LINK_EOC;
					r.cluster_out = c[15:0];
					r.byte_offset = cluster_offset(c);
					granted.push_back(c[15:0]);
					if (granted.size() > 64)
						void'(granted.pop_front());
				end
			end
			CMD_FREE: begin
				c = clus;
				while (c >= FIRST_CLUSTER && c < LINK_END_MIN && r.status == ST_OK) begin
					if (c >= TABLE_N) begin
						r.status = ST_RANGE;
					end else if (cnt >= TABLE_N) begin
						r.status = ST_LONG;
					end else begin
						nxt = fat[c];
						fat[c] = LINK_FREE;
						cnt++;
						c = nxt;
					end
				end
				r.freed_count = cnt[12:0];
			end
			default: begin
				if (clus >= TABLE_N)
					r.status = ST_RANGE;
				else
					fat[clus] = val;
			end
		endcase
		return r;
	endfunction

	function automatic void apply_setting(cfg_idx_t idx, logic [15:0] d);
		case (idx)
			CFG_BPS: g_bps = {19'd0, d[12:0]};
			CFG_SPC: g_spc = {24'd0, d[7:0]};
			CFG_RSV: g_rsv = {16'd0, d};
			CFG_COPIES: g_copies = {24'd0, d[7:0]};
			CFG_SPT: g_spt = {16'd0, d};
			CFG_ROOT: g_root = {16'd0, d};
			default: ;
		endcase
	endfunction

	function automatic void add_step(cmd_t cmd, logic [15:0] clus, logic [15:0] val,
			bit typed = 1'b0, status_t st = ST_OK, logic [15:0] co = '0, logic ce = 1'b0,
			logic [31:0] offs = '0, logic [12:0] cnt = '0);
		step_t s;
		s.cmd = cmd;
		s.clus = clus;
		s.val = val;
		s.typed = typed;
		s.want.status = st;
		s.want.cluster_out = co;
		s.want.chain_end = ce;
		s.want.byte_offset = offs;
		s.want.freed_count = cnt;
		script.push_back(s);
	endfunction

	function automatic logic [15:0] pick_cluster();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return $urandom_range(2, 40);
		else if (r < 9)
			return $urandom_range(0, TABLE_N - 1);
		else
			return $urandom_range(0, 16'hFFFF);
	endfunction

	// Link written at the tail of a built chain: mostly an end mark.
	function automatic logic [15:0] chain_tail();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			6: return LINK_FREE;
			7: return 16'd1;
			8: return $urandom_range(TABLE_N, LINK_END_MIN - 1);
			9: return pick_cluster();
			default: return $urandom_range(LINK_END_MIN, LINK_EOC);
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] wanted);
		if (errors < PRINT_CAP)
			$display("mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
				what, results_seen, got, wanted);
		errors++;
	endtask

	task automatic check_result();
		result_t want;
		if (awaited.size() == 0) begin
			report_mismatch("result with none outstanding", m_axis_tdata[31:0], 32'd0);
		end else begin
			want = awaited.pop_front();
			if (m_axis_tuser != want.status)
				report_mismatch("status", m_axis_tuser, want.status);
			if (m_axis_tdata[15:0] != want.cluster_out)
				report_mismatch("cluster_out", m_axis_tdata[15:0], want.cluster_out);
			if (m_axis_tdata[16] != want.chain_end)
				report_mismatch("chain_end", m_axis_tdata[16], want.chain_end);
			if (m_axis_tdata[48:17] != want.byte_offset)
				report_mismatch("byte_offset", m_axis_tdata[48:17], want.byte_offset);
			if (m_axis_tdata[61:49] != want.freed_count)
				report_mismatch("freed_count", m_axis_tdata[61:49], want.freed_count);
		end
		results_seen++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_result();
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
				$display("fat16_cluster_table_engine test failed");
				$finish;
			end
		end
	end

	// Result side: stretches of steady, light and heavy back-pressure, plus a long
	// hold-off on request so the engine backs up into its input.
	initial begin : sink
		int mode;
		int n;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			mode = $urandom_range(0, 2);
			n = $urandom_range(8, 64);
			repeat (n) begin
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 3) != 0);
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	task automatic pace();
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150) :
				$urandom_range(1, 12);
		end
		burst_left--;
	endtask

	task automatic send_item(cmd_t cmd, logic [15:0] clus, logic [15:0] val,
			bit typed = 1'b0, result_t want = '0);
		result_t predicted;
		pace();
		s_axis_tuser <= cmd;
		s_axis_tdata <= {val, clus};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		predicted = run_fat_command(cmd, clus, val);
		awaited.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (awaited.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(cfg_idx_t idx, logic [15:0] d);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		apply_setting(idx, d);
	endtask

	task automatic program_geometry(logic [15:0] bps, logic [15:0] spc, logic [15:0] rsv,
			logic [15:0] copies, logic [15:0] spt, logic [15:0] root);
		cfg_write(CFG_BPS, bps);
		cfg_write(CFG_SPC, spc);
		cfg_write(CFG_RSV, rsv);
		cfg_write(CFG_COPIES, copies);
		cfg_write(CFG_SPT, spt);
		cfg_write(CFG_ROOT, root);
		cfg_valid <= 1'b0;
	endtask

	// Follows a chain through the mirrored table, stopping at its end or after eight links.
	task automatic walk_chain(logic [15:0] start);
		logic [15:0] c;
		int n;
		bit more;
		c = start;
		n = 0;
		more = 1'b1;
		while (more && n < 8) begin
			send_item(CMD_FOLLOW, c, $urandom_range(0, 16'hFFFF));
			n++;
			more = (c < TABLE_N) && (fat[c] >= FIRST_CLUSTER) && (fat[c] < LINK_END_MIN);
			if (more)
				c = fat[c];
		end
	endtask

	task automatic run_random(int count);
		int stop_at;
		int kind;
		int len;
		int i;
		bit drained;
		logic [15:0] links [8];
		stop_at = items_sent + count;
		drained = 1'b0;
		while (items_sent < stop_at) begin
			if (!drained && items_sent >= stop_at - count / 2) begin
				wait_for_results();
				drained = 1'b1;
			end
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2: begin
					len = $urandom_range(1, 6);
					for (i = 0; i < len; i++)
						links[i] = pick_cluster();
					for (i = 0; i < len; i++)
						send_item(CMD_LOAD, links[i], (i == len - 1) ? chain_tail() : links[i + 1]);
					if ($urandom_range(0, 1))
						walk_chain(links[0]);
					if ($urandom_range(0, 1))
						send_item(CMD_FREE, links[0], $urandom_range(0, 16'hFFFF));
				end
				3: begin
					repeat ($urandom_range(1, 4))
						send_item(CMD_ALLOC, $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
				end
				4, 5: walk_chain(pick_cluster());
				6: send_item(CMD_FREE, pick_cluster(), $urandom_range(0, 16'hFFFF));
				7: begin
					if (granted.size() != 0) begin
						i = $urandom_range(0, granted.size() - 1);
						send_item(CMD_FREE, granted[i], 16'h0);
						granted.delete(i);
					end
				end
				8: send_item(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 16'hFFFF),
					$urandom_range(0, 16'hFFFF));
				default: send_item(CMD_LOAD, pick_cluster(), $urandom_range(0, 16'hFFFF));
			endcase
		end
	endtask

	// Links every cluster into one long chain so that allocation finds nothing,
	// then releases the whole table in a single walk.
	task automatic fill_table();
		logic [15:0] c;
		for (c = FIRST_CLUSTER; c < TABLE_N; c++)
			send_item(CMD_LOAD, c, (c == TABLE_N - 1) ? LINK_EOC : c + 16'd1);
		send_item(CMD_ALLOC, 16'h0, 16'h0);
		send_item(CMD_FOLLOW, TABLE_N - 1, 16'h0);
		send_item(CMD_FREE, FIRST_CLUSTER, 16'h0);
		send_item(CMD_ALLOC, 16'h0, 16'h0);
	endtask

	initial begin : stimulus
		int p;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_FOLLOW;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BPS;
		cfg_data = '0;
		foreach (fat[i])
			fat[i] = LINK_FREE;
		g_bps = 32'd512;
		g_spc = 32'd4;
		g_rsv = 32'd1;
		g_copies = 32'd2;
		g_spt = 32'd16;
		g_root = 32'd512;

		// With the reset geometry the data area starts at sector 65, byte 33280.
		add_step(CMD_FOLLOW, 16'd2, 16'h0, 1, ST_OK, LINK_FREE, 1'b1, 32'd33280);
		add_step(CMD_ALLOC, 16'h0, 16'h0, 1, ST_OK, 16'd2, 1'b0, 32'd33280);
		add_step(CMD_FOLLOW, 16'd2, 16'h0, 1, ST_OK, LINK_EOC, 1'b1, 32'd33280);
		add_step(CMD_FOLLOW, 16'd0, 16'h0);
		add_step(CMD_FOLLOW, 16'd4095, 16'hFFFF);
		add_step(CMD_FOLLOW, 16'd4096, 16'h0, 1, ST_RANGE);
		add_step(CMD_FOLLOW, 16'hFFFF, 16'h0, 1, ST_RANGE);
		add_step(CMD_LOAD, 16'hFFFF, 16'h1234, 1, ST_RANGE);
		add_step(CMD_LOAD, 16'd3, 16'd4, 1, ST_OK);
		add_step(CMD_LOAD, 16'd4, 16'd5, 1, ST_OK);
		add_step(CMD_LOAD, 16'd5, LINK_END_MIN, 1, ST_OK);
		add_step(CMD_FOLLOW, 16'd3, 16'h0);
		add_step(CMD_FOLLOW, 16'd5, 16'h0);
		add_step(CMD_FREE, 16'd3, 16'h0, 1, ST_OK, '0, 1'b0, '0, 13'd3);
		// A chain that runs off the table keeps what it already released.
		add_step(CMD_LOAD, 16'd6, 16'h1000);
		add_step(CMD_LOAD, 16'd7, 16'd6);
		add_step(CMD_FREE, 16'd7, 16'h0, 1, ST_RANGE, '0, 1'b0, '0, 13'd2);
		add_step(CMD_LOAD, 16'd8, LINK_END_MIN - 16'd1);
		add_step(CMD_FOLLOW, 16'd8, 16'h0);
		add_step(CMD_FREE, 16'd8, 16'h0, 1, ST_RANGE, '0, 1'b0, '0, 13'd1);
		add_step(CMD_LOAD, 16'd9, 16'd1);
		add_step(CMD_FOLLOW, 16'd9, 16'h0);
		add_step(CMD_FREE, 16'd0, 16'h0, 1, ST_OK);
		add_step(CMD_FREE, LINK_END_MIN, 16'h0, 1, ST_OK);
		add_step(CMD_FREE, LINK_END_MIN - 16'd1, 16'h0, 1, ST_RANGE);
		add_step(CMD_ALLOC, 16'h0, 16'h0, 1, ST_OK, 16'd3, 1'b0, 32'd35328);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[k])
			send_item(script[k].cmd, script[k].clus, script[k].val, script[k].typed,
				script[k].want);
		wait_for_results();

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: program_geometry(16'd4096, 16'd128, 16'hFFFF, 16'd255, 16'hFFFF, 16'hFFFF);
				1: program_geometry(16'd512, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0);
				2: program_geometry(16'd0, 16'd4, 16'd1, 16'd2, 16'd16, 16'd512);
				3: program_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				4: program_geometry(16'd1024, 16'd8, 16'd32, 16'd2, 16'd256, 16'd512);
				default: program_geometry(
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'hFFFF) :
						$urandom_range(512, 4096),
					$urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
					$urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
					$urandom_range(0, 16'hFFFF));
			endcase
			if (p == 1 || p == 4)
				hold_request = 1'b1;
			run_random(PHASE_ITEMS);
			wait_for_results();
		end

		fill_table();
		wait_for_results();
		repeat (END_SETTLE) @(posedge clk);
		if (errors == 0)
			$display("fat16_cluster_table_engine test passed");
		else
			$display("fat16_cluster_table_engine test failed");
		$finish;
	end

endmodule
